### src/batched_matrix_multiply_macros.svh
// assertion macros for the batched matrix multiply rtl
// expects signals named clock and reset in the including module
`ifndef BATCHED_MATRIX_MULTIPLY_MACROS_SVH
`define BATCHED_MATRIX_MULTIPLY_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BMM_ASSERT_IMP(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("bmm assertion failed");

// antecedent implies consequent in the next cycle
`define BMM_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("bmm assertion failed");

`endif

### src/bmm_pkg.sv
// shared constants and types for the batched matrix multiply
// no dependencies
`default_nettype none

package bmm_pkg;

   localparam int MAX_ROWS_DEFAULT   = 8;
   localparam int MAX_INNER_DEFAULT  = 8;
   localparam int MAX_COLS_DEFAULT   = 8;
   localparam int VALUE_BITS_DEFAULT = 16;

   localparam int ELEMENT_BITS  = 16;
   localparam int PRODUCT_BITS  = 35;
   localparam int INDEX_BITS    = 3;
   localparam int COUNT_BITS    = 4;
   localparam int RESULT_LIMIT  = 64;
   localparam int RESULT_BITS   = 6;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INNER_COUNT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COL_COUNT   = 2'd2;

   localparam logic OP_LOAD_LEFT  = 1'b0;
   localparam logic OP_LOAD_RIGHT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_HOLD  = 4'b1000
   } state_type;

endpackage

`default_nettype wire

### src/batched_matrix_multiply.sv
// batched matrix multiply: element loading, memory-based mac sequencer, result register
// depends on bmm_pkg and batched_matrix_multiply_macros.svh
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   operation, element_value
//   rsp      out        rsp_valid / rsp_stall   product_value, out_row, out_col, last_element
//   csr      in         apb write/read          row_count, inner_count, col_count
//
// a loading transaction that completes both matrices starts the run
// each result element goes through the single mac and memory read port
// req_stall is high for the whole run; a stalled result holds the sequencer
// synchronous reset sets the counts to one and clears fills and control; store contents are not cleared
`default_nettype none

`include "batched_matrix_multiply_macros.svh"

module batched_matrix_multiply #(
   parameter int MAX_ROWS   = bmm_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_INNER  = bmm_pkg::MAX_INNER_DEFAULT,
   parameter int MAX_COLS   = bmm_pkg::MAX_COLS_DEFAULT,
   parameter int VALUE_BITS = bmm_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire logic                                     req_operation,
   input  wire logic signed [bmm_pkg::ELEMENT_BITS-1:0]  req_element_value,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output logic signed [bmm_pkg::PRODUCT_BITS-1:0]       rsp_product_value,
   output logic [bmm_pkg::INDEX_BITS-1:0]                rsp_out_row,
   output logic [bmm_pkg::INDEX_BITS-1:0]                rsp_out_col,
   output logic                                          rsp_last_element,
   input  wire logic                                     csr_psel,
   input  wire logic                                     csr_penable,
   input  wire logic                                     csr_pwrite,
   input  wire logic [bmm_pkg::CSR_ADDR_BITS-1:0]        csr_paddr,
   input  wire logic [bmm_pkg::CSR_DATA_BITS-1:0]        csr_pwdata,
   output logic [bmm_pkg::CSR_DATA_BITS-1:0]             csr_prdata,
   output logic                                          csr_pready
);

   localparam int LeftDepth  = MAX_ROWS * MAX_INNER;
   localparam int RightDepth = MAX_INNER * MAX_COLS;
   localparam int LeftAddrW  = (LeftDepth > 1) ? $clog2(LeftDepth) : 1;
   localparam int RightAddrW = (RightDepth > 1) ? $clog2(RightDepth) : 1;
   localparam int LeftFillW  = $clog2(LeftDepth + 1);
   localparam int RightFillW = $clog2(RightDepth + 1);
   localparam int RowCntW    = $clog2(MAX_ROWS + 1);
   localparam int InnerCntW  = $clog2(MAX_INNER + 1);
   localparam int ColCntW    = $clog2(MAX_COLS + 1);
   localparam int RowIdxW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int InnerIdxW  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
   localparam int ColIdxW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ProdW      = 2 * VALUE_BITS;
   localparam int AccW       = bmm_pkg::PRODUCT_BITS;
   localparam int CntBits    = bmm_pkg::COUNT_BITS;
   localparam int IdxBits    = bmm_pkg::INDEX_BITS;
   localparam int ResW       = bmm_pkg::RESULT_BITS;
   localparam int CmpW       = 8;

   // configuration registers
   logic [CntBits-1:0] row_count_ff, inner_count_ff, col_count_ff;
   logic               csr_write;
   logic [bmm_pkg::CSR_INDEX_BITS-1:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[bmm_pkg::CSR_ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= CntBits'(1);
         inner_count_ff <= CntBits'(1);
         col_count_ff   <= CntBits'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            bmm_pkg::REG_ROW_COUNT:   row_count_ff   <= csr_pwdata[CntBits-1:0];
            bmm_pkg::REG_INNER_COUNT: inner_count_ff <= csr_pwdata[CntBits-1:0];
            bmm_pkg::REG_COL_COUNT:   col_count_ff   <= csr_pwdata[CntBits-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         bmm_pkg::REG_ROW_COUNT:   csr_prdata = bmm_pkg::CSR_DATA_BITS'(row_count_ff);
         bmm_pkg::REG_INNER_COUNT: csr_prdata = bmm_pkg::CSR_DATA_BITS'(inner_count_ff);
         bmm_pkg::REG_COL_COUNT:   csr_prdata = bmm_pkg::CSR_DATA_BITS'(col_count_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // effective dimensions: zero acts as one, too large acts as the maximum
   logic [RowCntW-1:0]   rows_eff;
   logic [InnerCntW-1:0] inner_eff;
   logic [ColCntW-1:0]   cols_eff;

   always_comb begin
      if (row_count_ff == '0)
         rows_eff = RowCntW'(1);
      else if (CmpW'(row_count_ff) > CmpW'(MAX_ROWS))
         rows_eff = RowCntW'(MAX_ROWS);
      else
         rows_eff = RowCntW'(row_count_ff);
      if (inner_count_ff == '0)
         inner_eff = InnerCntW'(1);
      else if (CmpW'(inner_count_ff) > CmpW'(MAX_INNER))
         inner_eff = InnerCntW'(MAX_INNER);
      else
         inner_eff = InnerCntW'(inner_count_ff);
      if (col_count_ff == '0)
         cols_eff = ColCntW'(1);
      else if (CmpW'(col_count_ff) > CmpW'(MAX_COLS))
         cols_eff = ColCntW'(MAX_COLS);
      else
         cols_eff = ColCntW'(col_count_ff);
   end

   logic [LeftFillW-1:0]  left_need;
   logic [RightFillW-1:0] right_need;

   assign left_need  = LeftFillW'(rows_eff) * LeftFillW'(inner_eff);
   assign right_need = RightFillW'(inner_eff) * RightFillW'(cols_eff);

   // sequencer state
   bmm_pkg::state_type state_ff, state_in;
   logic [LeftFillW-1:0]  left_fill_ff, left_fill_in;
   logic [RightFillW-1:0] right_fill_ff, right_fill_in;
   logic [RowIdxW-1:0]    r_ff, r_in;
   logic [ColIdxW-1:0]    c_ff, c_in;
   logic [InnerIdxW-1:0]  m_ff, m_in;
   logic [LeftAddrW-1:0]  left_base_ff, left_base_in;
   logic [RightAddrW-1:0] right_ptr_ff, right_ptr_in;
   logic [ResW-1:0]       res_cnt_ff, res_cnt_in;

   logic req_take, rsp_take;
   logic left_wr, right_wr, batch_done;
   logic signed [VALUE_BITS-1:0] elem;
   logic [31:0] elem_wide;
   logic m_last, r_last, c_last, elem_final;
   logic rd_en;

   assign req_stall = (state_ff != bmm_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;

   assign elem_wide = 32'(unsigned'(req_element_value));
   assign elem      = elem_wide[VALUE_BITS-1:0];

   assign left_wr  = req_take && (req_operation == bmm_pkg::OP_LOAD_LEFT)
                     && (left_fill_ff < left_need);
   assign right_wr = req_take && (req_operation == bmm_pkg::OP_LOAD_RIGHT)
                     && (right_fill_ff < right_need);

   assign batch_done = ((left_fill_ff + LeftFillW'(left_wr)) >= left_need)
                       && ((right_fill_ff + RightFillW'(right_wr)) >= right_need);

   assign m_last = (InnerCntW'(m_ff) == inner_eff - InnerCntW'(1));
   assign r_last = (RowCntW'(r_ff) == rows_eff - RowCntW'(1));
   assign c_last = (ColCntW'(c_ff) == cols_eff - ColCntW'(1));
   assign elem_final = (r_last && c_last) || (res_cnt_ff == ResW'(bmm_pkg::RESULT_LIMIT - 1));
   assign rd_en = (state_ff == bmm_pkg::ST_ISSUE);

   // accumulate pipeline tags
   logic p1_vld_ff, p1_last_ff, p2_vld_ff, p2_last_ff;
   logic signed [VALUE_BITS-1:0] left_q_ff, right_q_ff;
   logic signed [ProdW-1:0]      prod_ff;
   logic signed [AccW-1:0]       acc_ff, acc_sum;

   assign acc_sum = acc_ff + AccW'(prod_ff);

   always_comb begin
      state_in      = state_ff;
      left_fill_in  = left_fill_ff;
      right_fill_in = right_fill_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      m_in          = m_ff;
      left_base_in  = left_base_ff;
      right_ptr_in  = right_ptr_ff;
      res_cnt_in    = res_cnt_ff;
      unique case (state_ff)
         bmm_pkg::ST_IDLE: begin
            if (req_take) begin
               if (batch_done) begin
                  left_fill_in  = '0;
                  right_fill_in = '0;
                  r_in          = '0;
                  c_in          = '0;
                  m_in          = '0;
                  left_base_in  = '0;
                  right_ptr_in  = '0;
                  res_cnt_in    = '0;
                  state_in      = bmm_pkg::ST_ISSUE;
               end else begin
                  left_fill_in  = left_fill_ff + LeftFillW'(left_wr);
                  right_fill_in = right_fill_ff + RightFillW'(right_wr);
               end
            end
         end
         bmm_pkg::ST_ISSUE: begin
            if (m_last) begin
               state_in = bmm_pkg::ST_DRAIN;
            end else begin
               m_in         = m_ff + InnerIdxW'(1);
               right_ptr_in = right_ptr_ff + RightAddrW'(cols_eff);
            end
         end
         bmm_pkg::ST_DRAIN: begin
            if (p2_vld_ff && p2_last_ff)
               state_in = bmm_pkg::ST_HOLD;
         end
         bmm_pkg::ST_HOLD: begin
            if (rsp_take) begin
               if (elem_final) begin
                  state_in = bmm_pkg::ST_IDLE;
               end else begin
                  m_in       = '0;
                  res_cnt_in = res_cnt_ff + ResW'(1);
                  if (c_last) begin
                     c_in         = '0;
                     r_in         = r_ff + RowIdxW'(1);
                     left_base_in = left_base_ff + LeftAddrW'(inner_eff);
                     right_ptr_in = '0;
                  end else begin
                     c_in         = c_ff + ColIdxW'(1);
                     right_ptr_in = RightAddrW'(c_ff) + RightAddrW'(1);
                  end
                  state_in = bmm_pkg::ST_ISSUE;
               end
            end
         end
         default: state_in = bmm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bmm_pkg::ST_IDLE;
         left_fill_ff  <= '0;
         right_fill_ff <= '0;
         r_ff          <= '0;
         c_ff          <= '0;
         m_ff          <= '0;
         left_base_ff  <= '0;
         right_ptr_ff  <= '0;
         res_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         left_fill_ff  <= left_fill_in;
         right_fill_ff <= right_fill_in;
         r_ff          <= r_in;
         c_ff          <= c_in;
         m_ff          <= m_in;
         left_base_ff  <= left_base_in;
         right_ptr_ff  <= right_ptr_in;
         res_cnt_ff    <= res_cnt_in;
      end
   end

   // element stores, written only while idle, read only while issuing
   logic signed [VALUE_BITS-1:0] left_mem [LeftDepth];
   logic signed [VALUE_BITS-1:0] right_mem [RightDepth];
   logic [LeftAddrW-1:0]  left_rd_addr;
   logic [RightAddrW-1:0] right_rd_addr;

   assign left_rd_addr  = left_base_ff + LeftAddrW'(m_ff);
   assign right_rd_addr = right_ptr_ff;

   always_ff @(posedge clock) begin
      if (left_wr)
         left_mem[left_fill_ff[LeftAddrW-1:0]] <= elem;
      if (rd_en)
         left_q_ff <= left_mem[left_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (right_wr)
         right_mem[right_fill_ff[RightAddrW-1:0]] <= elem;
      if (rd_en)
         right_q_ff <= right_mem[right_rd_addr];
   end

   // multiply then accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff  <= 1'b0;
         p1_last_ff <= 1'b0;
         p2_vld_ff  <= 1'b0;
         p2_last_ff <= 1'b0;
         acc_ff     <= '0;
      end else begin
         p1_vld_ff  <= rd_en;
         p1_last_ff <= rd_en && m_last;
         p2_vld_ff  <= p1_vld_ff;
         p2_last_ff <= p1_last_ff;
         if (p2_vld_ff) begin
            if (p2_last_ff)
               acc_ff <= '0;
            else
               acc_ff <= acc_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p1_vld_ff)
         prod_ff <= left_q_ff * right_q_ff;
   end

   // result register
   logic rsp_valid_ff;
   logic signed [AccW-1:0] rsp_value_ff;
   logic [IdxBits-1:0] rsp_row_ff, rsp_col_ff;
   logic rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (p2_vld_ff && p2_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (p2_vld_ff && p2_last_ff) begin
         rsp_value_ff <= acc_sum;
         rsp_row_ff   <= IdxBits'(r_ff);
         rsp_col_ff   <= IdxBits'(c_ff);
         rsp_last_ff  <= r_last && c_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_last_element  = rsp_last_ff;

   `BMM_ASSERT_IMP(a_rsp_only_in_hold, rsp_valid_ff, state_ff == bmm_pkg::ST_HOLD)
   `BMM_ASSERT_IMP(a_finish_only_in_drain, p2_vld_ff && p2_last_ff,
                   state_ff == bmm_pkg::ST_DRAIN)
   `BMM_ASSERT_IMP(a_issue_in_range, state_ff == bmm_pkg::ST_ISSUE,
                   (InnerCntW'(m_ff) < inner_eff) && (RowCntW'(r_ff) < rows_eff)
                   && (ColCntW'(c_ff) < cols_eff))
   `BMM_ASSERT_IMP(a_fill_bounded, 1'b1,
                   (left_fill_ff <= LeftFillW'(LeftDepth))
                   && (right_fill_ff <= RightFillW'(RightDepth)))
   `BMM_ASSERT_NEXT(a_issue_ends_in_drain, state_ff == bmm_pkg::ST_ISSUE && m_last,
                    state_ff == bmm_pkg::ST_DRAIN && p1_vld_ff && p1_last_ff)

endmodule

`default_nettype wire

### verif/batched_matrix_multiply_check.sv
// checker for the batched matrix multiply: watches the element, result and register ports,
// keeps its own copy of the stores and counts, and compares every result transaction
// depends on bmm_pkg
module batched_matrix_multiply_check (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic                                    req_operation,
   input  logic signed [bmm_pkg::ELEMENT_BITS-1:0] req_element_value,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic signed [bmm_pkg::PRODUCT_BITS-1:0] rsp_product_value,
   input  logic [bmm_pkg::INDEX_BITS-1:0]          rsp_out_row,
   input  logic [bmm_pkg::INDEX_BITS-1:0]          rsp_out_col,
   input  logic                                    rsp_last_element,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [bmm_pkg::CSR_ADDR_BITS-1:0]       csr_paddr,
   input  logic [bmm_pkg::CSR_DATA_BITS-1:0]       csr_pwdata,
   input  logic                                    csr_pready,
   output int                                      mismatch_count,
   output int                                      outstanding_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = bmm_pkg::MAX_ROWS_DEFAULT * bmm_pkg::MAX_INNER_DEFAULT;
   localparam int COUNT_W = bmm_pkg::COUNT_BITS;

   typedef struct packed {
      logic signed [bmm_pkg::PRODUCT_BITS-1:0] product;
      logic [bmm_pkg::INDEX_BITS-1:0]          row;
      logic [bmm_pkg::INDEX_BITS-1:0]          col;
      logic                                    last;
   } result_element_type;

   result_element_type expected_elements[$];
   logic signed [bmm_pkg::ELEMENT_BITS-1:0] left_matrix [STORE_DEPTH];
   logic signed [bmm_pkg::ELEMENT_BITS-1:0] right_matrix [STORE_DEPTH];
   int left_fill;
   int right_fill;
   logic [COUNT_W-1:0] row_setting;
   logic [COUNT_W-1:0] inner_setting;
   logic [COUNT_W-1:0] col_setting;

   function automatic int clamp_count(logic [COUNT_W-1:0] value, int limit);
      if (value == 0)
         return 1;
      if (value > limit)
         return limit;
      return int'(value);
   endfunction

   task automatic load_element(logic op, logic signed [bmm_pkg::ELEMENT_BITS-1:0] value);
      int rows;
      int inner;
      int cols;
      longint sum;
      result_element_type element;
      rows = clamp_count(row_setting, bmm_pkg::MAX_ROWS_DEFAULT);
      inner = clamp_count(inner_setting, bmm_pkg::MAX_INNER_DEFAULT);
      cols = clamp_count(col_setting, bmm_pkg::MAX_COLS_DEFAULT);
      if (op == bmm_pkg::OP_LOAD_LEFT) begin
         if (left_fill < rows * inner) begin
            left_matrix[left_fill] = value;
            left_fill++;
         end
      end else begin
         if (right_fill < inner * cols) begin
            right_matrix[right_fill] = value;
            right_fill++;
         end
      end
      if (left_fill >= rows * inner && right_fill >= inner * cols) begin
         for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
               sum = 0;
               for (int m = 0; m < inner; m++)
                  sum += longint'(left_matrix[r * inner + m]) *
                         longint'(right_matrix[m * cols + c]);
               element.product = sum[bmm_pkg::PRODUCT_BITS-1:0];
               element.row = r[bmm_pkg::INDEX_BITS-1:0];
               element.col = c[bmm_pkg::INDEX_BITS-1:0];
               element.last = (r == rows - 1) && (c == cols - 1);
               expected_elements.push_back(element);
            end
         end
         left_fill = 0;
         right_fill = 0;
      end
   endtask

   task automatic check_result();
      result_element_type seen;
      result_element_type wanted;
      seen.product = rsp_product_value;
      seen.row = rsp_out_row;
      seen.col = rsp_out_col;
      seen.last = rsp_last_element;
      if (expected_elements.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t unexpected result: product %h row %0d col %0d last %0b",
                     $realtime, seen.product, seen.row, seen.col, seen.last);
      end else begin
         wanted = expected_elements.pop_front();
         if (seen.product !== wanted.product || seen.row !== wanted.row ||
             seen.col !== wanted.col || seen.last !== wanted.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t mismatch: expected %h %0d %0d %0b, got %h %0d %0d %0b",
                        $realtime,
                        wanted.product, wanted.row, wanted.col, wanted.last,
                        seen.product, seen.row, seen.col, seen.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         row_setting = COUNT_W'(1);
         inner_setting = COUNT_W'(1);
         col_setting = COUNT_W'(1);
         left_fill = 0;
         right_fill = 0;
         mismatch_count = 0;
         expected_elements.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[bmm_pkg::CSR_ADDR_BITS-1:2])
               bmm_pkg::REG_ROW_COUNT:   row_setting = csr_pwdata[COUNT_W-1:0];
               bmm_pkg::REG_INNER_COUNT: inner_setting = csr_pwdata[COUNT_W-1:0];
               bmm_pkg::REG_COL_COUNT:   col_setting = csr_pwdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            load_element(req_operation, req_element_value);
         if (rsp_valid && !rsp_stall)
            check_result();
      end
      outstanding_count = expected_elements.size();
   end

endmodule

### verif/batched_matrix_multiply_test.sv
// top of the batched matrix multiply testbench: clock, reset, element and register stimulus,
// random result stalls, a watchdog and the verdict
// depends on bmm_pkg, batched_matrix_multiply and batched_matrix_multiply_check
module batched_matrix_multiply_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_OFF = 16;
   localparam int RANDOM_LOADS = 255;
   localparam int COUNT_W = bmm_pkg::COUNT_BITS;
   localparam int ELEMENT_W = bmm_pkg::ELEMENT_BITS;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    req_valid = 1'b0;
   logic                                    req_stall;
   logic                                    req_operation = bmm_pkg::OP_LOAD_LEFT;
   logic signed [ELEMENT_W-1:0]             req_element_value = '0;
   logic                                    rsp_valid;
   logic                                    rsp_stall = 1'b0;
   logic signed [bmm_pkg::PRODUCT_BITS-1:0] rsp_product_value;
   logic [bmm_pkg::INDEX_BITS-1:0]          rsp_out_row;
   logic [bmm_pkg::INDEX_BITS-1:0]          rsp_out_col;
   logic                                    rsp_last_element;
   logic                                    csr_psel = 1'b0;
   logic                                    csr_penable = 1'b0;
   logic                                    csr_pwrite = 1'b0;
   logic [bmm_pkg::CSR_ADDR_BITS-1:0]       csr_paddr = '0;
   logic [bmm_pkg::CSR_DATA_BITS-1:0]       csr_pwdata = '0;
   logic [bmm_pkg::CSR_DATA_BITS-1:0]       csr_prdata;
   logic                                    csr_pready;

   int mismatch_count;
   int outstanding_count;
   int quiet_cycles = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int loaded = 0;
   logic [COUNT_W-1:0] row_value = COUNT_W'(1);
   logic [COUNT_W-1:0] inner_value = COUNT_W'(1);
   logic [COUNT_W-1:0] col_value = COUNT_W'(1);

   batched_matrix_multiply dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_product_value (rsp_product_value),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_last_element  (rsp_last_element),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   batched_matrix_multiply_check check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_product_value (rsp_product_value),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_last_element  (rsp_last_element),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int clamp_count(logic [COUNT_W-1:0] value, int limit);
      if (value == 0)
         return 1;
      if (value > limit)
         return limit;
      return int'(value);
   endfunction

   function automatic logic signed [ELEMENT_W-1:0] random_element();
      case ($urandom_range(7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return ELEMENT_W'($urandom);
      endcase
   endfunction

   function automatic void set_idling(int mode);
      case (mode % 4)
         0: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
         1: begin
            sender_idle_pct = 55;
            receiver_stall_pct = 0;
         end
         2: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 55;
         end
         default: begin
            sender_idle_pct = 12;
            receiver_stall_pct = 12;
         end
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after the transaction
   task automatic send_element(logic op, logic signed [ELEMENT_W-1:0] value);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < sender_idle_pct)
         gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_element_value <= value;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_register(logic [bmm_pkg::CSR_INDEX_BITS-1:0] index,
                                 logic [COUNT_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {28'($urandom), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      case (index)
         bmm_pkg::REG_ROW_COUNT:   row_value = value;
         bmm_pkg::REG_INNER_COUNT: inner_value = value;
         default:                  col_value = value;
      endcase
   endtask

   // sender pauses until every result has come, then lets the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding_count != 0)
         @(negedge clock);
      repeat (HOLD_OFF) @(negedge clock);
   endtask

   task automatic run_batch();
      int left_todo;
      int right_todo;
      logic cut_short;
      left_todo = clamp_count(row_value, bmm_pkg::MAX_ROWS_DEFAULT) *
                  clamp_count(inner_value, bmm_pkg::MAX_INNER_DEFAULT);
      right_todo = clamp_count(inner_value, bmm_pkg::MAX_INNER_DEFAULT) *
                   clamp_count(col_value, bmm_pkg::MAX_COLS_DEFAULT);
      cut_short = ($urandom_range(7) == 0);
      while (left_todo + right_todo > 0) begin
         if (cut_short && $urandom_range(3) == 0)
            break;
         if ((left_todo == 0 || right_todo == 0) && $urandom_range(9) == 0) begin
            // one matrix is full, this element is dropped
            send_element(left_todo == 0 ? bmm_pkg::OP_LOAD_LEFT : bmm_pkg::OP_LOAD_RIGHT,
                         random_element());
         end else if (right_todo == 0 || (left_todo != 0 && $urandom_range(1) == 0)) begin
            send_element(bmm_pkg::OP_LOAD_LEFT, random_element());
            left_todo--;
            loaded++;
         end else begin
            send_element(bmm_pkg::OP_LOAD_RIGHT, random_element());
            right_todo--;
            loaded++;
         end
      end
   endtask

   initial begin
      int phase;
      int batches;
      logic big_done;
      phase = 0;
      big_done = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset sizes 1x1x1, extremes, a dropped element, right before left
      send_element(bmm_pkg::OP_LOAD_LEFT, 16'sh8000);
      send_element(bmm_pkg::OP_LOAD_LEFT, 16'sh1234);
      send_element(bmm_pkg::OP_LOAD_RIGHT, 16'sh8000);
      send_element(bmm_pkg::OP_LOAD_LEFT, 16'sh7fff);
      send_element(bmm_pkg::OP_LOAD_RIGHT, 16'sh7fff);
      send_element(bmm_pkg::OP_LOAD_RIGHT, 16'sh7fff);
      send_element(bmm_pkg::OP_LOAD_LEFT, 16'sh8000);
      drain_results();

      // zero counts act as one
      write_register(bmm_pkg::REG_ROW_COUNT, 4'd0);
      write_register(bmm_pkg::REG_INNER_COUNT, 4'd0);
      write_register(bmm_pkg::REG_COL_COUNT, 4'd0);
      send_element(bmm_pkg::OP_LOAD_RIGHT, 16'sh0100);
      send_element(bmm_pkg::OP_LOAD_LEFT, 16'shffff);
      drain_results();

      // shrinking the right matrix to its fill fires on the next, dropped, element
      write_register(bmm_pkg::REG_ROW_COUNT, 4'd2);
      write_register(bmm_pkg::REG_INNER_COUNT, 4'd2);
      write_register(bmm_pkg::REG_COL_COUNT, 4'd2);
      repeat (4) send_element(bmm_pkg::OP_LOAD_LEFT, random_element());
      repeat (2) send_element(bmm_pkg::OP_LOAD_RIGHT, random_element());
      drain_results();
      write_register(bmm_pkg::REG_COL_COUNT, 4'd1);
      send_element(bmm_pkg::OP_LOAD_LEFT, random_element());
      drain_results();

      // oversized row count acts as the maximum
      set_idling(3);
      write_register(bmm_pkg::REG_ROW_COUNT, 4'd15);
      write_register(bmm_pkg::REG_INNER_COUNT, 4'd1);
      for (int i = 0; i < 8; i++)
         send_element(bmm_pkg::OP_LOAD_LEFT, i[0] ? 16'sh7fff : 16'sh8000);
      send_element(bmm_pkg::OP_LOAD_RIGHT, 16'sh8000);
      drain_results();

      while (loaded < RANDOM_LOADS) begin
         set_idling(phase);
         batches = $urandom_range(1, 3);
         if (!big_done && loaded > 80) begin
            write_register(bmm_pkg::REG_ROW_COUNT, 4'd8);
            write_register(bmm_pkg::REG_INNER_COUNT, 4'd15);
            write_register(bmm_pkg::REG_COL_COUNT, 4'd15);
            big_done = 1'b1;
            batches = 1;
         end else begin
            if (phase == 0 || $urandom_range(2) != 0)
               write_register(bmm_pkg::REG_ROW_COUNT, $urandom_range(9) == 0 ?
                              COUNT_W'($urandom_range(9, 15)) :
                              COUNT_W'($urandom_range(4)));
            if (phase == 0 || $urandom_range(2) != 0)
               write_register(bmm_pkg::REG_INNER_COUNT, $urandom_range(9) == 0 ?
                              COUNT_W'($urandom_range(9, 15)) :
                              COUNT_W'($urandom_range(4)));
            if (phase == 0 || $urandom_range(2) != 0)
               write_register(bmm_pkg::REG_COL_COUNT, $urandom_range(9) == 0 ?
                              COUNT_W'($urandom_range(9, 15)) :
                              COUNT_W'($urandom_range(4)));
         end
         repeat (batches) run_batch();
         drain_results();
         phase++;
      end

      drain_results();
      repeat (100) @(negedge clock);
      if (mismatch_count == 0 && outstanding_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/bmm_pkg.sv
src/batched_matrix_multiply.sv
verif/batched_matrix_multiply_check.sv
verif/batched_matrix_multiply_test.sv
